// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define AST_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define AST_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths and defaults for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int BASE_WIDTH = 63;
  localparam int EXPF_WIDTH = 63;
  localparam int RES_WIDTH  = 31;
  localparam int CFG_WIDTH  = 31;

  localparam int MOD_WIDTH_DEF = 31;
  localparam int EXP_WIDTH_DEF = 63;

  localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 31'd1000000007;

  localparam int CNT_WIDTH = $clog2(BASE_WIDTH);

endpackage

// ===== hdl/mexp_in_if.sv =====
// ----------------------------------------------------------------------------
// mexp_in_if
// input channel: base and exponent with valid/ready
// ----------------------------------------------------------------------------
interface mexp_in_if;
  import mexp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [BASE_WIDTH-1:0] base_value;
  logic [EXPF_WIDTH-1:0] exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

// ===== hdl/mexp_out_if.sv =====
// ----------------------------------------------------------------------------
// mexp_out_if
// result channel: reduced power with valid/ready
// ----------------------------------------------------------------------------
interface mexp_out_if;
  import mexp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RES_WIDTH-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

// ===== hdl/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// right-to-left square-and-multiply, base^exponent mod modulus, bit-serial
// throughput: one item at a time; a new input is taken only in the idle state,
//   which is entered when the result is loaded; loading waits while an
//   earlier result is not yet taken; set by the 63-step base reduction
//   and the bit-serial multipliers
// reset: synchronous, modulus returns to 1000000007, no item in flight
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [mexp_pkg::CFG_WIDTH-1:0] cfg_wr_data,
  mexp_in_if.sink                        in_ch,
  mexp_out_if.source                     out_ch
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  function automatic logic [MOD_WIDTH-1:0] red_step(
    input logic [MOD_WIDTH-1:0] r,
    input logic                 sel,
    input logic [MOD_WIDTH-1:0] m
  );
    logic [MOD_WIDTH:0] t;
    t = {r, sel};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[MOD_WIDTH-1:0];
  endfunction

  function automatic logic [MOD_WIDTH-1:0] mul_step(
    input logic [MOD_WIDTH-1:0] r,
    input logic                 sel,
    input logic [MOD_WIDTH-1:0] addend,
    input logic [MOD_WIDTH-1:0] m
  );
    logic [MOD_WIDTH+1:0] t;
    logic [MOD_WIDTH+1:0] m1;
    logic [MOD_WIDTH+1:0] m2;
    t  = {1'b0, r, 1'b0} + (sel ? {2'b00, addend} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2) t = t - m2;
    else if (t >= m1) t = t - m1;
    return t[MOD_WIDTH-1:0];
  endfunction

  logic [MOD_WIDTH-1:0]  modulus;
  logic [MOD_WIDTH-1:0]  m_eff;
  logic [2:0]            state;
  logic [CNT_WIDTH-1:0]  cnt;
  logic [BASE_WIDTH-1:0] base_sr;
  logic [EXP_WIDTH-1:0]  e;
  logic [MOD_WIDTH-1:0]  acc;
  logic [MOD_WIDTH-1:0]  b;
  logic [MOD_WIDTH-1:0]  xa;
  logic [MOD_WIDTH-1:0]  xb;
  logic [MOD_WIDTH-1:0]  ra;
  logic [MOD_WIDTH-1:0]  rb;
  logic                  out_valid;
  logic [RES_WIDTH-1:0]  out_data;

  assign m_eff = (modulus == '0) ? MOD_WIDTH'(1) : modulus;

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.power_result = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET[MOD_WIDTH-1:0];
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            base_sr <= in_ch.base_value;
            e       <= in_ch.exponent[EXP_WIDTH-1:0];
            acc     <= MOD_WIDTH'(1);
            rb      <= '0;
            cnt     <= CNT_WIDTH'(BASE_WIDTH - 1);
            state   <= S_RED;
          end
        end
        S_RED: begin
          rb      <= red_step(rb, base_sr[BASE_WIDTH-1], m_eff);
          base_sr <= base_sr << 1;
          if (cnt == '0) begin
            state <= S_UPD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_UPD: begin
          // first pass only moves the reduced base, e[0] acc update skipped
          b <= rb;
          if (cnt == '1) begin
            if (e[0]) acc <= ra;
            e <= e >> 1;
          end
          state <= S_CHK;
        end
        S_CHK: begin
          if (e == '0) begin
            state <= S_DONE;
          end else begin
            xa    <= acc;
            xb    <= b;
            ra    <= '0;
            rb    <= '0;
            cnt   <= CNT_WIDTH'(MOD_WIDTH - 1);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          ra  <= mul_step(ra, xa[MOD_WIDTH-1], b, m_eff);
          rb  <= mul_step(rb, xb[MOD_WIDTH-1], b, m_eff);
          xa  <= xa << 1;
          xb  <= xb << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_UPD;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data  <= RES_WIDTH'(acc);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks for modular_exponentiation_top, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mexp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `AST_ALL(a_rst_out_empty, rst |=> !out_valid, "result valid right after reset")
  `AST_ALL(a_rst_in_ready, rst |=> in_ready, "input not ready right after reset")
  `AST_RUN(a_busy_after_in, (in_valid && in_ready) |=> !in_ready, "second transfer while busy")
  `AST_RUN(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped before transfer")

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
